[hw/rtl/sha256_message_hasher_macros.svh]
// assertion macros used by the checker file
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

// property must hold at every clock edge outside reset
`define SHA_MH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define SHA_MH_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/sha_mh_pkg.sv]
// types, constants and round functions of the sha-256 message hasher
`timescale 1ns / 1ps

package sha_mh_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_HOLD
    } state_t;

    // where the sixteen message words of a block come from
    typedef enum logic [1:0] {
        BM_DATA,
        BM_PAD_FULL,
        BM_PAD_LAST,
        BM_PAD_LEN
    } blk_mode_t;

    // control from the sequencer to the round datapath
    typedef struct packed {
        logic        load_en;
        logic [2:0]  load_idx;
        logic [31:0] load_data;
        logic        round_en;
        logic [5:0]  round_idx;
        logic [31:0] msg_word;
        logic [2:0]  sel_idx;
    } core_ctl_t;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_START   = 6'd56;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [5:0] CHAIN_STEPS = 6'd8;
    localparam logic [3:0] LEN_HI_WORD = 4'd14;
    localparam logic [3:0] LEN_LO_WORD = 4'd15;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] ch_fn(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj_fn(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

[hw/rtl/sha_mh_if.sv]
// handshake interfaces for the message byte channel and the digest word channel
`timescale 1ns / 1ps

interface sha_mh_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;

    modport source (output valid, data_byte, byte_present, message_end, input ready);
    modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha_mh_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[hw/rtl/sha256_message_hasher.sv]
// top level of the sha-256 message hasher: sequencer, block and chain memories
`timescale 1ns / 1ps

// channel  | dir | handshake     | payload
// ---------+-----+---------------+------------------------------------------
// msg      | in  | valid / ready | data_byte, byte_present, message_end
// digest   | out | valid / ready | digest_word, word_index, last_word
//
// one cycle per message word while filling a block, none while a block is hashed;
// a full block loads a..h from the chain ram one word at a time over its single
// read port, runs 64 rounds at one per cycle, then adds back and writes the chain ram
// message end costs one or two padded blocks; digest words are then read out one by one
// rst_n clears the sequencer, fill count, bit count and marks the chain as iv
// a stalled digest word holds the block; no message word is taken meanwhile

module sha256_message_hasher import sha_mh_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    sha_mh_msg_if.sink      msg,
    sha_mh_digest_if.source digest
);

    // sequencer state
    state_t      state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    blk_mode_t   mode_reg, mode_next;
    // message bookkeeping
    logic [5:0]  fill_reg, fill_next;
    logic [23:0] partial_reg, partial_next;
    logic [54:0] blocks_reg, blocks_next;
    logic        end_pend_reg, end_pend_next;
    logic        init_reg, init_next;
    // digest output register
    logic [31:0] out_word_reg, out_word_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_valid_reg, out_valid_next;

    // memory ports
    logic        blk_wr_en;
    logic [3:0]  blk_wr_addr;
    logic [31:0] blk_wr_data;
    logic [3:0]  blk_rd_addr;
    logic [31:0] blk_rd_data;
    logic        ch_wr_en;
    logic [2:0]  ch_wr_addr;
    logic [31:0] ch_wr_data;
    logic [2:0]  ch_rd_addr;
    logic [31:0] ch_rd_data;

    core_ctl_t   core_ctl;
    logic [31:0] work_sel;

    logic [5:0]  step_m1;
    logic [5:0]  fill_after;
    logic        wrap;
    logic [31:0] chain_base;
    logic [31:0] pad_merge;
    logic [63:0] bit_len;
    logic [31:0] msg_word;
    logic [3:0]  word_t;

    // message words of the block, one 32-bit entry per four bytes
    sha_mh_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_blk_ram (
        .clk     (clk),
        .wr_en   (blk_wr_en),
        .wr_addr (blk_wr_addr),
        .wr_data (blk_wr_data),
        .rd_addr (blk_rd_addr),
        .rd_data (blk_rd_data)
    );

    // chaining words h0..h7
    sha_mh_ram #(
        .WIDTH (32),
        .DEPTH (8)
    ) u_chain_ram (
        .clk     (clk),
        .wr_en   (ch_wr_en),
        .wr_addr (ch_wr_addr),
        .wr_data (ch_wr_data),
        .rd_addr (ch_rd_addr),
        .rd_data (ch_rd_data)
    );

    sha_mh_core u_core (
        .clk      (clk),
        .ctl      (core_ctl),
        .work_sel (work_sel)
    );

    assign step_m1    = step_reg - 6'd1;
    assign fill_after = fill_reg + {5'd0, msg.byte_present};
    assign wrap       = msg.byte_present && (fill_reg == 6'd63);
    // chain reads as the initial hash until the first block of a message is folded in
    assign chain_base = init_reg ? SHA_IV[step_m1[2:0]] : ch_rd_data;
    // bit count: whole blocks times 512 plus the held bytes times 8
    assign bit_len    = {blocks_reg, fill_reg, 3'b000};
    assign word_t     = step_reg[3:0];

    // word holding the pad byte, after any partial bytes of the message
    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    pad_merge = {PAD_BYTE, 24'h0};
            2'd1:    pad_merge = {partial_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_merge = {partial_reg[15:0], PAD_BYTE, 8'h0};
            default: pad_merge = {partial_reg[23:0], PAD_BYTE};
        endcase
    end

    // message word fed to the rounds for the current block kind
    always_comb
    begin
        msg_word = 32'h0;
        case (mode_reg)
            BM_DATA:
            begin
                msg_word = blk_rd_data;
            end
            BM_PAD_FULL, BM_PAD_LAST:
            begin
                if (word_t < fill_reg[5:2])
                begin
                    msg_word = blk_rd_data;
                end
                else if (word_t == fill_reg[5:2])
                begin
                    msg_word = pad_merge;
                end
                else if (mode_reg == BM_PAD_LAST && word_t == LEN_HI_WORD)
                begin
                    msg_word = bit_len[63:32];
                end
                else if (mode_reg == BM_PAD_LAST && word_t == LEN_LO_WORD)
                begin
                    msg_word = bit_len[31:0];
                end
            end
            BM_PAD_LEN:
            begin
                if (word_t == LEN_HI_WORD)
                begin
                    msg_word = bit_len[63:32];
                end
                else if (word_t == LEN_LO_WORD)
                begin
                    msg_word = bit_len[31:0];
                end
            end
            default:
            begin
                msg_word = 32'h0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid && (wrap || msg.message_end))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (step_reg == CHAIN_STEPS)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (step_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (step_reg == CHAIN_STEPS)
                begin
                    case (mode_reg)
                        BM_DATA:     state_next = end_pend_reg ? ST_LOAD : ST_IDLE;
                        BM_PAD_FULL: state_next = ST_LOAD;
                        default:     state_next = ST_EMIT_RD;
                    endcase
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                state_next = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (digest.ready)
                begin
                    state_next = (step_reg[2:0] == 3'd7) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: memory ports, round control, channel handshakes
    always_comb
    begin
        msg.ready   = 1'b0;
        blk_wr_en   = 1'b0;
        blk_wr_addr = fill_reg[5:2];
        blk_wr_data = {partial_reg, msg.data_byte};
        blk_rd_addr = 4'd0;
        ch_wr_en    = 1'b0;
        ch_wr_addr  = step_m1[2:0];
        ch_wr_data  = chain_base + work_sel;
        ch_rd_addr  = step_reg[2:0];

        core_ctl.load_en   = 1'b0;
        core_ctl.load_idx  = step_m1[2:0];
        core_ctl.load_data = chain_base;
        core_ctl.round_en  = 1'b0;
        core_ctl.round_idx = step_reg;
        core_ctl.msg_word  = msg_word;
        core_ctl.sel_idx   = step_m1[2:0];

        case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                // fourth byte of a word goes to the block ram
                blk_wr_en = msg.valid && msg.byte_present && (fill_reg[1:0] == 2'd3);
            end
            ST_LOAD:
            begin
                // word 0 is fetched early so that round 0 finds it ready
                core_ctl.load_en = (step_reg != 6'd0);
            end
            ST_ROUND:
            begin
                core_ctl.round_en = 1'b1;
                blk_rd_addr       = word_t + 4'd1;
            end
            ST_FINAL:
            begin
                ch_wr_en = (step_reg != 6'd0);
            end
            default:
            begin
                msg.ready = 1'b0;
            end
        endcase
    end

    // next values of the bookkeeping and output registers
    always_comb
    begin
        step_next      = step_reg;
        mode_next      = mode_reg;
        fill_next      = fill_reg;
        partial_next   = partial_reg;
        blocks_next    = blocks_reg;
        end_pend_next  = end_pend_reg;
        init_next      = init_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    step_next = 6'd0;
                    if (msg.byte_present)
                    begin
                        partial_next = {partial_reg[15:0], msg.data_byte};
                        fill_next    = fill_after;
                    end
                    if (wrap)
                    begin
                        mode_next     = BM_DATA;
                        end_pend_next = msg.message_end;
                    end
                    else if (msg.message_end)
                    begin
                        mode_next = (fill_after >= LEN_START) ? BM_PAD_FULL : BM_PAD_LAST;
                    end
                end
            end
            ST_LOAD:
            begin
                step_next = (step_reg == CHAIN_STEPS) ? 6'd0 : step_reg + 6'd1;
            end
            ST_ROUND:
            begin
                step_next = step_reg + 6'd1;
            end
            ST_FINAL:
            begin
                if (step_reg == CHAIN_STEPS)
                begin
                    step_next = 6'd0;
                    init_next = 1'b0;
                    case (mode_reg)
                        BM_DATA:
                        begin
                            blocks_next = blocks_reg + 55'd1;
                            if (end_pend_reg)
                            begin
                                // message ended on a block boundary: pad block only
                                mode_next     = BM_PAD_LAST;
                                end_pend_next = 1'b0;
                            end
                        end
                        BM_PAD_FULL:
                        begin
                            mode_next = BM_PAD_LEN;
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            ST_EMIT_WAIT:
            begin
                out_word_next  = ch_rd_data;
                out_idx_next   = step_reg[2:0];
                out_valid_next = 1'b1;
            end
            ST_EMIT_HOLD:
            begin
                if (digest.ready)
                begin
                    out_valid_next = 1'b0;
                    if (step_reg[2:0] == 3'd7)
                    begin
                        // back to the start of a fresh message
                        step_next   = 6'd0;
                        fill_next   = 6'd0;
                        blocks_next = 55'd0;
                        init_next   = 1'b1;
                    end
                    else
                    begin
                        step_next = step_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 6'd0;
            mode_reg      <= BM_DATA;
            fill_reg      <= 6'd0;
            blocks_reg    <= 55'd0;
            end_pend_reg  <= 1'b0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            mode_reg      <= mode_next;
            fill_reg      <= fill_next;
            blocks_reg    <= blocks_next;
            end_pend_reg  <= end_pend_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        partial_reg  <= partial_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
    end

    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_idx_reg;
    assign digest.last_word   = (out_idx_reg == 3'd7);

endmodule

[hw/rtl/sha_mh_ram.sv]
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps

module sha_mh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/sha_mh_core.sv]
// round datapath: working variables a..h and the rolling message schedule
`timescale 1ns / 1ps

module sha_mh_core import sha_mh_pkg::*; (
    input  logic        clk,
    input  core_ctl_t   ctl,
    output logic [31:0] work_sel
);

    logic [31:0] work_reg  [8];
    logic [31:0] sched_reg [16];
    logic [31:0] w_t;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb
    begin
        // first sixteen rounds take the block word, later ones expand the window
        if (ctl.round_idx[5:4] == 2'b00)
        begin
            w_t = ctl.msg_word;
        end
        else
        begin
            w_t = ssig1(sched_reg[14]) + sched_reg[9] + ssig0(sched_reg[1]) + sched_reg[0];
        end
        t1 = work_reg[7] + bsig1(work_reg[4]) + ch_fn(work_reg[4], work_reg[5], work_reg[6])
             + ROUND_K[ctl.round_idx] + w_t;
        t2 = bsig0(work_reg[0]) + maj_fn(work_reg[0], work_reg[1], work_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_en)
        begin
            work_reg[ctl.load_idx] <= ctl.load_data;
        end
        else if (ctl.round_en)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
        if (ctl.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= w_t;
        end
    end

    assign work_sel = work_reg[ctl.sel_idx];

endmodule

[hw/rtl/sha_mh_checker.sv]
// port-level assertions for the sha-256 message hasher, bound to the top level
`timescale 1ns / 1ps
`include "sha256_message_hasher_macros.svh"

module sha_mh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_ready,
    input logic        msg_end,
    input logic        dig_valid,
    input logic        dig_ready,
    input logic [31:0] dig_word,
    input logic [2:0]  dig_index,
    input logic        dig_last
);

    // a stalled digest word stays put
    `SHA_MH_ASSERT(a_dig_hold, clk, rst_n, dig_valid && !dig_ready |=> dig_valid && $stable(dig_word) && $stable(dig_index), "digest word changed while stalled")

    // no message word is taken while the digest is being sent
    `SHA_MH_NEVER(a_no_overlap, clk, rst_n, msg_ready && dig_valid, "message taken during digest output")

    // message end always starts a block, so input closes at once
    `SHA_MH_ASSERT(a_end_closes, clk, rst_n, msg_valid && msg_ready && msg_end |=> !msg_ready, "input still open after message end")

    // nothing follows the last digest word
    `SHA_MH_ASSERT(a_last_done, clk, rst_n, dig_valid && dig_ready && dig_last |=> !dig_valid, "digest word after the last one")

endmodule

bind sha256_message_hasher sha_mh_checker u_sha_mh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .msg_end   (msg.message_end),
    .dig_valid (digest.valid),
    .dig_ready (digest.ready),
    .dig_word  (digest.digest_word),
    .dig_index (digest.word_index),
    .dig_last  (digest.last_word)
);

[test/testbench.sv]
// self-checking testbench for the sha-256 message hasher, random stalls on both channels
`timescale 1ns / 1ps

module testbench;

    // timing of the run
    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 600000;  // well above the slowest legal run
    localparam int DRAIN_CYCLES = 200;     // two padded blocks plus margin
    localparam int RANDOM_WORDS = 260;     // budget of message words sent in all, idle ones included

    // block layout of the hash
    localparam int         BLOCK_BYTES  = 64;
    localparam int         LEN_FIELD_AT = 56;  // first byte of the length field
    localparam bit [7:0]   PAD_MARK     = 8'h80;
    localparam bit [63:0]  BLOCK_BITS   = 64'd512;

    localparam bit [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one expected word of a digest
    typedef struct packed {
        bit [31:0] word;
        bit [2:0]  pos;
        bit        last;
    } digest_entry_t;

    // running hash of the message so far and the digest words still owed
    class digest_predictor;
        bit [7:0]      blk [BLOCK_BYTES];
        int unsigned   fill;
        bit [63:0]     hashed_bits;
        bit [31:0]     chain [8];
        digest_entry_t expected_words [$];
        int unsigned   mismatch_count;

        function new();
            mismatch_count = 0;
            restart();
        endfunction

        // fresh message: initial chaining value, nothing buffered
        function void restart();
            fill        = 0;
            hashed_bits = '0;
            foreach (chain[i])
                chain[i] = HASH_IV[i];
        endfunction

        function bit [31:0] ror(bit [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // 64 rounds over the buffered block, folded into the chain
        function void compress();
            bit [31:0] sched [64];
            bit [31:0] v [8];
            bit [31:0] t1;
            bit [31:0] t2;
            bit [31:0] s0;
            bit [31:0] s1;
            for (int i = 0; i < 16; i++)
                sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
                s1 = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
                sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
            end
            v = chain;
            for (int r = 0; r < 64; r++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + sched[r];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (chain[i])
                chain[i] += v[i];
        endfunction

        // an accepted message word; at message end the digest is queued
        function void note_msg_word(bit [7:0] data, bit present, bit fin);
            bit [63:0]     length_bits;
            int unsigned   held;
            digest_entry_t entry;
            if (present)
            begin
                blk[fill] = data;
                fill = (fill + 1) % BLOCK_BYTES;
                if (fill == 0)
                begin
                    compress();
                    hashed_bits += BLOCK_BITS;
                end
            end
            if (!fin)
                return;
            held        = fill;
            length_bits = hashed_bits + 64'(held) * 64'd8;
            blk[held]   = PAD_MARK;
            for (int i = held + 1; i < BLOCK_BYTES; i++)
                blk[i] = 8'h00;
            // no room left for the length: it goes into a block of its own
            if (held >= LEN_FIELD_AT)
            begin
                compress();
                for (int i = 0; i < LEN_FIELD_AT; i++)
                    blk[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                blk[BLOCK_BYTES - 1 - i] = length_bits[8*i +: 8];
            compress();
            for (int i = 0; i < 8; i++)
            begin
                entry.word = chain[i];
                entry.pos  = 3'(i);
                entry.last = (i == 7);
                expected_words.push_back(entry);
            end
            restart();
        endfunction

        // an accepted digest word against the oldest one owed
        function void check_digest_word(logic [31:0] word, logic [2:0] pos, logic last);
            digest_entry_t want;
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected digest word: expected none, actual %h pos %0d last %b",
                         $time, word, pos, last);
                return;
            end
            want = expected_words.pop_front();
            if (word !== want.word)
            begin
                mismatch_count++;
                $display("%0t: digest_word mismatch at pos %0d: expected %h, actual %h",
                         $time, want.pos, want.word, word);
            end
            if (pos !== want.pos)
            begin
                mismatch_count++;
                $display("%0t: word_index mismatch: expected %0d, actual %0d",
                         $time, want.pos, pos);
            end
            if (last !== want.last)
            begin
                mismatch_count++;
                $display("%0t: last_word mismatch at pos %0d: expected %b, actual %b",
                         $time, want.pos, want.last, last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sha_mh_msg_if    msg_ch ();
    sha_mh_digest_if digest_ch ();

    sha256_message_hasher u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (digest_ch)
    );

    digest_predictor predictor;
    int unsigned     words_sent;
    int unsigned     cycle_count;
    bit              quiet_spell;  // no idling on either side while set

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // mostly back to back, sometimes a few cycles, now and then a long pause
    function automatic int unsigned gap_len();
        int unsigned roll;
        if (quiet_spell)
            return 0;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // present one message word, hold it until taken, then note it
    task automatic send_msg_word(input logic [7:0] data, input logic present,
                                 input logic fin);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid        <= 1'b1;
        msg_ch.data_byte    <= data;
        msg_ch.byte_present <= present;
        msg_ch.message_end  <= fin;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        predictor.note_msg_word(data, present, fin);
        words_sent++;
    endtask

    // a whole message of random bytes, with the odd absent-byte word mixed in;
    // the last byte either rides on the end word or the end word stands alone
    task automatic send_message(input int unsigned len, input bit byte_on_end);
        int unsigned body;
        body = (byte_on_end && len != 0) ? len - 1 : len;
        for (int i = 0; i < body; i++)
        begin
            if ($urandom_range(9) == 0)
                send_msg_word(8'($urandom), 1'b0, 1'b0);
            send_msg_word(8'($urandom), 1'b1, 1'b0);
        end
        if (body != len)
            send_msg_word(8'($urandom), 1'b1, 1'b1);
        else
            send_msg_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // stimulus and end of run
    initial
    begin
        int unsigned roll;
        int unsigned len;
        rst_n               <= 1'b0;
        msg_ch.valid        <= 1'b0;
        msg_ch.data_byte    <= 8'h00;
        msg_ch.byte_present <= 1'b0;
        msg_ch.message_end  <= 1'b0;
        quiet_spell = 1'b0;
        words_sent  = 0;
        predictor   = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty message, straight after reset
        send_msg_word(8'h00, 1'b0, 1'b1);
        // idle word with all data bits set, then "abc" with the end on the last byte
        send_msg_word(8'hff, 1'b0, 1'b0);
        send_msg_word(8'h61, 1'b1, 1'b0);
        send_msg_word(8'h62, 1'b1, 1'b0);
        send_msg_word(8'h63, 1'b1, 1'b1);
        // single all-ones byte carried on the end word
        send_msg_word(8'hff, 1'b1, 1'b1);
        // zero byte, then an end word whose data must be ignored
        send_msg_word(8'h00, 1'b1, 1'b0);
        send_msg_word(8'ha5, 1'b0, 1'b1);
        // empty message again, junk on the data lines
        send_msg_word(8'hff, 1'b0, 1'b1);
        // absent byte in the middle of a message
        send_msg_word(8'h5a, 1'b1, 1'b0);
        send_msg_word(8'hc3, 1'b0, 1'b0);
        send_msg_word(8'h3c, 1'b1, 1'b1);

        // random messages; lengths cluster round the padding edges at 55/56 and 63/64
        while (words_sent < RANDOM_WORDS)
        begin
            quiet_spell = ($urandom_range(3) == 0);
            roll = $urandom_range(99);
            if (roll < 60)
                len = $urandom_range(12);
            else if (roll < 88)
                len = $urandom_range(70, 50);
            else
                len = $urandom_range(130, 110);
            // the last message is cut short so the run stays near its word budget
            if (len > RANDOM_WORDS - words_sent)
                len = RANDOM_WORDS - words_sent;
            send_message(len, $urandom_range(1));
        end
        msg_ch.valid <= 1'b0;
        quiet_spell = 1'b0;

        // let every owed digest arrive, then watch for stray words
        while (predictor.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (predictor.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // digest side: take words with random stalls and check each one
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        digest_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (digest_ch.valid && digest_ch.ready)
                predictor.check_digest_word(digest_ch.digest_word, digest_ch.word_index,
                                            digest_ch.last_word);
            if (stall_left != 0)
            begin
                stall_left--;
                digest_ch.ready <= 1'b0;
            end
            else
            begin
                stall_left = ($urandom_range(3) == 0) ? gap_len() : 0;
                digest_ch.ready <= (stall_left == 0);
            end
        end
    end

    // watchdog against a hung handshake
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d digest words still owed",
                 $time, cycle_count, predictor.expected_words.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sha_mh_pkg.sv
hw/rtl/sha_mh_if.sv
hw/rtl/sha_mh_ram.sv
hw/rtl/sha_mh_core.sv
hw/rtl/sha256_message_hasher.sv
hw/rtl/sha_mh_checker.sv
test/testbench.sv
